FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the tag store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BCPT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BCPT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCPT_ASSERT(label, clk, rst, prop, msg)
`define BCPT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/bcpt_pkg.sv
// Package with the constants, sequencer states and control types of the tag store.
package bcpt_pkg;

  localparam int DEF_WAYS        = 8;
  localparam int DEF_SET_BITS    = 6;
  localparam int DEF_OFFSET_BITS = 6;
  localparam int ADDR_W          = 32;
  localparam int REUSE_W         = 4;
  localparam int THR_W           = 8;

  localparam logic [REUSE_W-1:0] REUSE_MAX = 4'd15;
  localparam logic [THR_W-1:0]   THR_RESET = 8'd32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_APPLY,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic is_hit;
    logic ins_mru;
    logic target;
  } way_ctl_t;

endpackage

FILE: hw/rtl/bip_cache_per_set_throttle.sv
// Top level: bimodal-insertion LRU tag store with a per-set throttle, run by a way sequencer.
// Each word goes through a set read, a tag compare of each way and an update of each way
// through the way unit, and a write back that waits for a free result register; the next
// word is accepted only once that write back is done.
// After reset the block sweeps the set memory, one set a cycle, with input ready low;
// throttle_period resets to 32 and may be written at any time.
`include "assert_macros.svh"

module bip_cache_per_set_throttle #(
  parameter int WAYS        = bcpt_pkg::DEF_WAYS,
  parameter int SET_BITS    = bcpt_pkg::DEF_SET_BITS,
  parameter int OFFSET_BITS = bcpt_pkg::DEF_OFFSET_BITS,
  localparam int WW         = $clog2(WAYS),
  localparam int TAG_W      = bcpt_pkg::ADDR_W - SET_BITS - OFFSET_BITS,
  localparam int OUT_BITS   = 3 + WW + TAG_W + bcpt_pkg::REUSE_W,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bcpt_pkg::THR_W-1:0]   cfg_wr_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // Fields from bit 0: address.
  input  logic [bcpt_pkg::ADDR_W-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // Fields from bit 0: hit, way, inserted_mru, evicted, evicted_tag, evicted_reuse, zero pad.
  output logic [OUT_W-1:0]             m_axis_tdata
);

  localparam int AGE_W = WW;
  localparam logic [WW-1:0] LAST_WAY = WW'(WAYS - 1);

  bcpt_pkg::state_t state, state_next;

  logic [bcpt_pkg::THR_W-1:0]             throttle_period;
  logic [SET_BITS-1:0]                    clr_idx;
  logic [WW-1:0]                          idx;
  logic [SET_BITS-1:0]                    set_q;
  logic [TAG_W-1:0]                       tag_q;
  logic [WAYS-1:0]                        row_v;
  logic [WAYS-1:0][TAG_W-1:0]             row_tag;
  logic [WAYS-1:0][AGE_W-1:0]             row_age;
  logic [WAYS-1:0][bcpt_pkg::REUSE_W-1:0] row_reuse;
  logic                                   full_q;
  logic [bcpt_pkg::THR_W-1:0]             thr_q;
  logic                                   hit_found;
  logic [WW-1:0]                          hit_way;
  logic [AGE_W-1:0]                       hit_age;
  logic                                   vic_found;
  logic [WW-1:0]                          vic_way;
  logic                                   all_valid;
  logic                                   ev_q;
  logic [TAG_W-1:0]                       ev_tag_q;
  logic [bcpt_pkg::REUSE_W-1:0]           ev_reuse_q;
  logic                                   out_valid;
  logic [OUT_W-1:0]                       out_data;

  logic                                   in_accept;
  logic                                   out_free;
  logic                                   last_way;
  logic                                   thr_match;
  logic                                   ins_mru;
  logic [WW-1:0]                          tgt_way;
  logic                                   full_new;
  logic [bcpt_pkg::THR_W-1:0]             thr_new;
  logic [OUT_W-1:0]                       out_data_next;

  logic                                   mem_wr_en;
  logic [SET_BITS-1:0]                    mem_rd_addr;
  logic [SET_BITS-1:0]                    mem_wr_addr;
  logic                                   mem_clear;
  logic [WAYS-1:0]                        rd_valid;
  logic [WAYS-1:0][TAG_W-1:0]             rd_tag;
  logic [WAYS-1:0][AGE_W-1:0]             rd_age;
  logic [WAYS-1:0][bcpt_pkg::REUSE_W-1:0] rd_reuse;
  logic                                   rd_full;
  logic [bcpt_pkg::THR_W-1:0]             rd_thr;

  bcpt_pkg::way_ctl_t                     way_ctl;
  logic                                   wu_match;
  logic                                   wu_victim;
  logic                                   wu_v;
  logic [TAG_W-1:0]                       wu_tag;
  logic [AGE_W-1:0]                       wu_age;
  logic [bcpt_pkg::REUSE_W-1:0]           wu_reuse;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid || m_axis_tready;
  assign last_way  = (idx == LAST_WAY);
  assign thr_match = (thr_q == throttle_period);
  assign ins_mru   = !full_q || thr_match;
  assign tgt_way   = hit_found ? hit_way : vic_way;

  assign way_ctl.is_hit  = hit_found;
  assign way_ctl.ins_mru = ins_mru;
  assign way_ctl.target  = (idx == tgt_way);

  assign full_new = (!hit_found && ins_mru && !thr_match) ? all_valid : full_q;
  assign thr_new  = hit_found ? thr_q :
                    (thr_match ? bcpt_pkg::THR_W'(1) : thr_q + bcpt_pkg::THR_W'(1));

  assign out_data_next = OUT_W'({ev_reuse_q, ev_tag_q, ev_q, !hit_found && ins_mru,
                                 tgt_way, hit_found});

  bcpt_way_unit #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .AGE_W (AGE_W)
  ) u_way_unit (
    .ctl        (way_ctl),
    .v_in       (row_v[idx]),
    .tag_in     (row_tag[idx]),
    .age_in     (row_age[idx]),
    .reuse_in   (row_reuse[idx]),
    .lookup_tag (tag_q),
    .hit_age    (hit_age),
    .tag_match  (wu_match),
    .victim_ok  (wu_victim),
    .v_out      (wu_v),
    .tag_out    (wu_tag),
    .age_out    (wu_age),
    .reuse_out  (wu_reuse)
  );

  bcpt_set_mem #(
    .WAYS     (WAYS),
    .SET_BITS (SET_BITS),
    .TAG_W    (TAG_W),
    .AGE_W    (AGE_W)
  ) u_set_mem (
    .clk      (clk),
    .rd_addr  (mem_rd_addr),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_valid (mem_clear ? '0 : row_v),
    .wr_tag   (mem_clear ? '0 : row_tag),
    .wr_age   (mem_clear ? '0 : row_age),
    .wr_reuse (mem_clear ? '0 : row_reuse),
    .wr_full  (mem_clear ? 1'b0 : full_new),
    .wr_thr   (mem_clear ? '0 : thr_new),
    .rd_valid (rd_valid),
    .rd_tag   (rd_tag),
    .rd_age   (rd_age),
    .rd_reuse (rd_reuse),
    .rd_full  (rd_full),
    .rd_thr   (rd_thr)
  );

  always_comb begin
    state_next = state;
    case (state)
      bcpt_pkg::ST_CLEAR: begin
        if (&clr_idx) state_next = bcpt_pkg::ST_IDLE;
      end
      bcpt_pkg::ST_IDLE: begin
        if (in_accept) state_next = bcpt_pkg::ST_LOAD;
      end
      bcpt_pkg::ST_LOAD: begin
        state_next = bcpt_pkg::ST_SCAN;
      end
      bcpt_pkg::ST_SCAN: begin
        if (last_way) state_next = bcpt_pkg::ST_APPLY;
      end
      bcpt_pkg::ST_APPLY: begin
        if (last_way) state_next = bcpt_pkg::ST_WRITE;
      end
      bcpt_pkg::ST_WRITE: begin
        if (out_free) state_next = bcpt_pkg::ST_IDLE;
      end
      default: begin
        state_next = bcpt_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mem_wr_en     = 1'b0;
    mem_clear     = 1'b0;
    mem_wr_addr   = set_q;
    mem_rd_addr   = set_q;
    case (state)
      bcpt_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_clear   = 1'b1;
        mem_wr_addr = clr_idx;
      end
      bcpt_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_rd_addr   = s_axis_tdata[OFFSET_BITS +: SET_BITS];
      end
      bcpt_pkg::ST_WRITE: begin
        mem_wr_en = out_free;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= bcpt_pkg::ST_CLEAR;
      clr_idx         <= '0;
      throttle_period <= bcpt_pkg::THR_RESET;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bcpt_pkg::ST_CLEAR) clr_idx <= clr_idx + SET_BITS'(1);
      if (cfg_wr_en) throttle_period <= cfg_wr_data;
      if (state == bcpt_pkg::ST_WRITE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bcpt_pkg::ST_IDLE: begin
        set_q <= s_axis_tdata[OFFSET_BITS +: SET_BITS];
        tag_q <= s_axis_tdata[bcpt_pkg::ADDR_W-1 -: TAG_W];
      end
      bcpt_pkg::ST_LOAD: begin
        row_v     <= rd_valid;
        row_tag   <= rd_tag;
        row_age   <= rd_age;
        row_reuse <= rd_reuse;
        full_q    <= rd_full;
        thr_q     <= rd_thr;
        idx       <= '0;
        hit_found <= 1'b0;
        hit_way   <= '0;
        hit_age   <= '0;
        vic_found <= 1'b0;
        vic_way   <= '0;
      end
      bcpt_pkg::ST_SCAN: begin
        if (wu_match && !hit_found) begin
          hit_found <= 1'b1;
          hit_way   <= idx;
          hit_age   <= row_age[idx];
        end
        if (wu_victim && !vic_found) begin
          vic_found <= 1'b1;
          vic_way   <= idx;
        end
        idx       <= last_way ? '0 : idx + WW'(1);
        all_valid <= 1'b1;
        ev_q      <= 1'b0;
        ev_tag_q  <= '0;
        ev_reuse_q <= '0;
      end
      bcpt_pkg::ST_APPLY: begin
        row_v[idx]     <= wu_v;
        row_tag[idx]   <= wu_tag;
        row_age[idx]   <= wu_age;
        row_reuse[idx] <= wu_reuse;
        all_valid      <= all_valid && wu_v;
        if (way_ctl.target && !hit_found && row_v[idx]) begin
          ev_q       <= 1'b1;
          ev_tag_q   <= row_tag[idx];
          ev_reuse_q <= row_reuse[idx];
        end
        idx <= last_way ? '0 : idx + WW'(1);
      end
      bcpt_pkg::ST_WRITE: begin
        if (out_free) out_data <= out_data_next;
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  `BCPT_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> state == bcpt_pkg::ST_CLEAR, "reset must start the memory sweep")
  `BCPT_ASSERT(a_accept_loads, clk, rst, in_accept |=> state == bcpt_pkg::ST_LOAD, "accepted word must start a set read")
  `BCPT_ASSERT(a_hold_on_stall, clk, rst, (state == bcpt_pkg::ST_WRITE && !out_free) |=> state == bcpt_pkg::ST_WRITE, "write back must wait for a free result register")
  `BCPT_ASSERT(a_hit_no_evict, clk, rst, (state == bcpt_pkg::ST_WRITE && hit_found) |-> !ev_q, "a hit must not report an eviction")

endmodule

FILE: hw/rtl/bcpt_set_mem.sv
// Set memory holding valid, tag, age and reuse of every way plus per-set full and throttle.
module bcpt_set_mem #(
  parameter int WAYS     = bcpt_pkg::DEF_WAYS,
  parameter int SET_BITS = bcpt_pkg::DEF_SET_BITS,
  parameter int TAG_W    = 20,
  parameter int AGE_W    = 3
) (
  input  logic                                   clk,
  input  logic [SET_BITS-1:0]                    rd_addr,
  input  logic                                   wr_en,
  input  logic [SET_BITS-1:0]                    wr_addr,
  input  logic [WAYS-1:0]                        wr_valid,
  input  logic [WAYS-1:0][TAG_W-1:0]             wr_tag,
  input  logic [WAYS-1:0][AGE_W-1:0]             wr_age,
  input  logic [WAYS-1:0][bcpt_pkg::REUSE_W-1:0] wr_reuse,
  input  logic                                   wr_full,
  input  logic [bcpt_pkg::THR_W-1:0]             wr_thr,
  output logic [WAYS-1:0]                        rd_valid,
  output logic [WAYS-1:0][TAG_W-1:0]             rd_tag,
  output logic [WAYS-1:0][AGE_W-1:0]             rd_age,
  output logic [WAYS-1:0][bcpt_pkg::REUSE_W-1:0] rd_reuse,
  output logic                                   rd_full,
  output logic [bcpt_pkg::THR_W-1:0]             rd_thr
);

  localparam int NSETS = 1 << SET_BITS;

  logic [WAYS-1:0]                        valid_mem [NSETS];
  logic [WAYS-1:0][TAG_W-1:0]             tag_mem   [NSETS];
  logic [WAYS-1:0][AGE_W-1:0]             age_mem   [NSETS];
  logic [WAYS-1:0][bcpt_pkg::REUSE_W-1:0] reuse_mem [NSETS];
  logic                                   full_mem  [NSETS];
  logic [bcpt_pkg::THR_W-1:0]             thr_mem   [NSETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      valid_mem[wr_addr] <= wr_valid;
      tag_mem[wr_addr]   <= wr_tag;
      age_mem[wr_addr]   <= wr_age;
      reuse_mem[wr_addr] <= wr_reuse;
      full_mem[wr_addr]  <= wr_full;
      thr_mem[wr_addr]   <= wr_thr;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid_mem[rd_addr];
    rd_tag   <= tag_mem[rd_addr];
    rd_age   <= age_mem[rd_addr];
    rd_reuse <= reuse_mem[rd_addr];
    rd_full  <= full_mem[rd_addr];
    rd_thr   <= thr_mem[rd_addr];
  end

endmodule

FILE: hw/rtl/bcpt_way_unit.sv
// Shared per-way unit: tag compare and victim test, then the age, reuse and fill update of one way.
module bcpt_way_unit #(
  parameter int WAYS  = bcpt_pkg::DEF_WAYS,
  parameter int TAG_W = 20,
  parameter int AGE_W = 3
) (
  input  bcpt_pkg::way_ctl_t              ctl,
  input  logic                            v_in,
  input  logic [TAG_W-1:0]                tag_in,
  input  logic [AGE_W-1:0]                age_in,
  input  logic [bcpt_pkg::REUSE_W-1:0]    reuse_in,
  input  logic [TAG_W-1:0]                lookup_tag,
  input  logic [AGE_W-1:0]                hit_age,
  output logic                            tag_match,
  output logic                            victim_ok,
  output logic                            v_out,
  output logic [TAG_W-1:0]                tag_out,
  output logic [AGE_W-1:0]                age_out,
  output logic [bcpt_pkg::REUSE_W-1:0]    reuse_out
);

  localparam logic [AGE_W-1:0] LRU_AGE = AGE_W'(WAYS - 1);

  logic [AGE_W-1:0] age_inc;

  assign age_inc   = age_in + AGE_W'(1);
  assign tag_match = v_in && (tag_in == lookup_tag);
  assign victim_ok = !v_in || (age_in == LRU_AGE);

  always_comb begin
    v_out     = v_in;
    tag_out   = tag_in;
    age_out   = age_in;
    reuse_out = reuse_in;
    if (ctl.is_hit) begin
      if (ctl.target) begin
        age_out = '0;
        if (reuse_in != bcpt_pkg::REUSE_MAX) begin
          reuse_out = reuse_in + bcpt_pkg::REUSE_W'(1);
        end
      end else if (v_in && (age_in < hit_age)) begin
        age_out = age_inc;
      end
    end else begin
      if (ctl.target) begin
        v_out     = 1'b1;
        tag_out   = lookup_tag;
        reuse_out = '0;
        age_out   = ctl.ins_mru ? '0 : LRU_AGE;
      end else if (ctl.ins_mru && v_in) begin
        age_out = age_inc;
      end
    end
  end

endmodule
